// ===== rtl/core/sph_density_summation_macros.svh =====
// assertion macros for the sph density summation block
`ifndef SPH_DENSITY_SUMMATION_MACROS_SVH
`define SPH_DENSITY_SUMMATION_MACROS_SVH
`ifndef SYNTHESIS
`define SPH_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define SPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assertion failed");
`else
`define SPH_ASSERT_IMPL(label, clk, rst_n, prop)
`define SPH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/sphd_pkg.sv =====
// package: types, constants and codes of the sph density summation block
`timescale 1ns / 1ps
`default_nettype none
package sphd_pkg;
	localparam int COORD_FRAC_BITS_DEF = 24;
	localparam int QF = 30;
	localparam logic [31:0] INV_H_RESET = 32'd1310720;
	localparam logic [31:0] KCONST_RESET = 32'd250329170;
	localparam logic [31:0] K_TWO_THIRDS = 32'd715827883;
	localparam logic [31:0] K_ONE_SIXTH = 32'd178956971;
	localparam logic [47:0] DENS_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic REG_INV_H = 1'b0;
	localparam logic REG_KCONST = 1'b1;

	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] nb_x;
		logic signed [31:0] nb_y;
		logic signed [31:0] nb_z;
		logic [31:0] nb_weight;
		logic first;
		logic last;
	} in_beat_t;

	typedef struct packed {
		logic [47:0] density;
		logic saturated;
	} out_beat_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DX, ST_DY, ST_DZ, ST_SQRT, ST_QLO, ST_QHI, ST_QCHK,
		ST_A2, ST_A3, ST_AW, ST_B2, ST_B3, ST_B6, ST_TERM, ST_ACC,
		ST_DLO, ST_DHI, ST_DOUT, ST_WAIT
	} state_t;

	// operand select of the shared multiplier
	typedef struct packed {
		logic [32:0] a;
		logic [32:0] b;
	} mul_req_t;
endpackage
`default_nettype wire

// ===== rtl/core/sphd_mul.sv =====
// shared 33x33 unsigned multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module sphd_mul (
	input wire logic clk,
	input wire sphd_pkg::mul_req_t req,
	output logic [65:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= 66'(req.a) * 66'(req.b);
	end
endmodule
`default_nettype wire

// ===== rtl/core/sphd_isqrt.sv =====
// iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module sphd_isqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [65:0] radicand,
	output logic busy,
	output logic [32:0] root_q
);
	logic [65:0] rad_q;
	logic [35:0] rem_q;
	logic [5:0] cnt_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;

	assign rem_sh = {rem_q[33:0], rad_q[65:64]};
	assign trial = {1'b0, root_q, 2'b01};
	assign busy = cnt_q != 6'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd33;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy) begin
			rad_q <= {rad_q[63:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[31:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[31:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/sph_density_summation.sv =====
// sph density summation: top level with sequencer, accumulator and output register
//
// usage:
//   one input beat carries a target/neighbour pair, its weight and first/last
//   flags; a beat is taken when in_valid is high and in_stall is low
//   in_stall is high while a pair is in work or a result beat still waits
//   after a pair is taken the block works through: three squares through the
//   shared multiplier, the square root, two products for q and its range check,
//   none to three kernel products (zero kernel, q below 1, q from 1 to 2), then
//   the weight product and the accumulate
//   so a pair without last returns the block to idle after the accumulate
//   a last pair then adds two density products and raises out_valid; the result
//   beat is held until out_stall is low, and the block is idle again once it
//   leaves
//   configuration beats (index 0: inv_h, index 1: density scale) are always
//   accepted and must only come while the block is idle
//   reset clears the sum, the saturation flag and loads register defaults
//   first clears the sum before adding; without first the pair adds on
`timescale 1ns / 1ps
`default_nettype none
`include "sph_density_summation_macros.svh"
module sph_density_summation #(
	parameter int COORD_FRAC_BITS = sphd_pkg::COORD_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire sphd_pkg::in_beat_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output sphd_pkg::out_beat_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam int PSHIFT = COORD_FRAC_BITS + 16 - sphd_pkg::QF;

	sphd_pkg::state_t state_q, state_d;
	sphd_pkg::in_beat_t in_q;
	sphd_pkg::mul_req_t req;
	logic [65:0] prod;
	logic [31:0] inv_h_q, kconst_q;
	logic [63:0] sum_q;
	logic sat_q;
	logic [65:0] sq_q;
	logic [65:0] radicand;
	logic [32:0] root;
	logic sqrt_busy, sqrt_start;
	logic sqrt_started_q;
	logic [65:0] p_q;        // r * inv_h, exact
	logic [31:0] q_q;        // q, Q2.30
	logic [31:0] x2_q;       // q^2
	logic [31:0] w_q;        // kernel value Q.30
	logic zero_w_q;
	logic [32:0] dx, dy, dz;
	logic take;

	assign take = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// absolute differences, exact in 33 bits
	function automatic logic [32:0] absdiff(input logic [31:0] a, input logic [31:0] b);
		logic signed [32:0] d;
		d = 33'(signed'(a)) - 33'(signed'(b));
		return d[32] ? 33'(-d) : 33'(d);
	endfunction
	assign dx = absdiff(in_q.target_x, in_q.nb_x);
	assign dy = absdiff(in_q.target_y, in_q.nb_y);
	assign dz = absdiff(in_q.target_z, in_q.nb_z);

	sphd_mul u_mul (.clk(clk), .req(req), .prod_q(prod));

	// dx^2 + dy^2 sits in sq_q, dz^2 arrives from the multiplier on the start cycle
	assign radicand = sq_q + prod;
	assign sqrt_start = state_q == sphd_pkg::ST_SQRT && !sqrt_started_q && !sqrt_busy;
	sphd_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .radicand(radicand),
		.busy(sqrt_busy), .root_q(root)
	);

	// q truncation from the exact product
	logic [31:0] q_next;
	always_comb begin
		if (PSHIFT >= 0) q_next = 32'(p_q >> PSHIFT);
		else q_next = 32'(p_q << (-PSHIFT));
	end

	// sequencer: next state and multiplier operands
	always_comb begin
		state_d = state_q;
		req = '0;
		unique case (state_q)
			sphd_pkg::ST_IDLE: if (take) state_d = sphd_pkg::ST_DX;
			sphd_pkg::ST_DX: begin req.a = dx; req.b = dx; state_d = sphd_pkg::ST_DY; end
			sphd_pkg::ST_DY: begin req.a = dy; req.b = dy; state_d = sphd_pkg::ST_DZ; end
			sphd_pkg::ST_DZ: begin req.a = dz; req.b = dz; state_d = sphd_pkg::ST_SQRT; end
			sphd_pkg::ST_SQRT:
				if (sqrt_started_q && !sqrt_busy) state_d = sphd_pkg::ST_QLO;
			sphd_pkg::ST_QLO: begin
				req.a = {1'b0, root[31:0]}; req.b = {1'b0, inv_h_q};
				state_d = sphd_pkg::ST_QHI;
			end
			sphd_pkg::ST_QHI: begin
				req.a = {32'd0, root[32]}; req.b = {1'b0, inv_h_q};
				state_d = sphd_pkg::ST_QCHK;
			end
			sphd_pkg::ST_QCHK: state_d = sphd_pkg::ST_A2;
			sphd_pkg::ST_A2: begin
				// q_q loads at the end of this cycle, so branch on q_next
				if (zero_w_q) state_d = sphd_pkg::ST_TERM;
				else if (!q_next[30] && !q_next[31]) begin
					req.a = {1'b0, q_next}; req.b = {1'b0, q_next}; state_d = sphd_pkg::ST_A3;
				end else begin
					req.a = {1'b0, 32'h8000_0000 - q_next}; req.b = req.a;
					state_d = sphd_pkg::ST_B2;
				end
			end
			sphd_pkg::ST_A3: begin
				req.a = {1'b0, prod[61:30]}; req.b = {1'b0, q_q}; state_d = sphd_pkg::ST_AW;
			end
			sphd_pkg::ST_AW: state_d = sphd_pkg::ST_TERM;
			sphd_pkg::ST_B2: begin
				req.a = {1'b0, prod[61:30]}; req.b = {1'b0, 32'h8000_0000 - q_q};
				state_d = sphd_pkg::ST_B3;
			end
			sphd_pkg::ST_B3: begin
				req.a = {1'b0, prod[61:30]}; req.b = {1'b0, sphd_pkg::K_ONE_SIXTH};
				state_d = sphd_pkg::ST_B6;
			end
			sphd_pkg::ST_B6: state_d = sphd_pkg::ST_TERM;
			sphd_pkg::ST_TERM: begin
				req.a = {1'b0, in_q.nb_weight}; req.b = {1'b0, w_q};
				state_d = sphd_pkg::ST_ACC;
			end
			sphd_pkg::ST_ACC: state_d = in_q.last ? sphd_pkg::ST_DLO : sphd_pkg::ST_IDLE;
			sphd_pkg::ST_DLO: begin
				req.a = {1'b0, sum_q[31:0]}; req.b = {1'b0, kconst_q};
				state_d = sphd_pkg::ST_DHI;
			end
			sphd_pkg::ST_DHI: begin
				req.a = {1'b0, sum_q[63:32]}; req.b = {1'b0, kconst_q};
				state_d = sphd_pkg::ST_DOUT;
			end
			sphd_pkg::ST_DOUT: state_d = sphd_pkg::ST_WAIT;
			sphd_pkg::ST_WAIT: if (!out_stall) state_d = sphd_pkg::ST_IDLE;
			default: state_d = sphd_pkg::ST_IDLE;
		endcase
	end

	assign in_stall = state_q != sphd_pkg::ST_IDLE;
	assign out_valid = state_q == sphd_pkg::ST_WAIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sphd_pkg::ST_IDLE;
			inv_h_q <= sphd_pkg::INV_H_RESET;
			kconst_q <= sphd_pkg::KCONST_RESET;
			sum_q <= '0;
			sat_q <= 1'b0;
			sqrt_started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					sphd_pkg::REG_INV_H: inv_h_q <= cfg_data;
					sphd_pkg::REG_KCONST: kconst_q <= cfg_data;
					default: ;
				endcase
			end
			sqrt_started_q <= state_q == sphd_pkg::ST_SQRT && (sqrt_started_q || sqrt_start);
			// accumulate the term, clearing first on a run start
			if (state_q == sphd_pkg::ST_ACC) begin
				logic [63:0] base;
				logic [64:0] ns;
				base = in_q.first ? 64'd0 : sum_q;
				ns = {1'b0, base} + {25'd0, prod[63:24]};
				if (ns[64]) begin
					sum_q <= '1;
					sat_q <= 1'b1;
				end else begin
					sum_q <= ns[63:0];
					sat_q <= in_q.first ? 1'b0 : sat_q;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (take) begin
			in_q <= in_data;
			zero_w_q <= 1'b0;
		end
		unique case (state_q)
			sphd_pkg::ST_DY: sq_q <= prod;
			sphd_pkg::ST_DZ: sq_q <= sq_q + prod;
			sphd_pkg::ST_QHI: p_q <= prod;
			sphd_pkg::ST_QCHK: begin
				// high part must fit in 32 bits and the sum below the limit of two
				if (prod[65:32] != 34'd0) zero_w_q <= 1'b1;
				else begin
					logic [66:0] p;
					p = {1'b0, p_q} + {1'b0, prod[31:0], 32'd0};
					if (p >= (67'd2 << (COORD_FRAC_BITS + 16))) zero_w_q <= 1'b1;
					p_q <= p[65:0];
				end
			end
			sphd_pkg::ST_A2: begin
				q_q <= q_next;
				if (zero_w_q) w_q <= '0;
			end
			sphd_pkg::ST_A3: x2_q <= prod[61:30];
			sphd_pkg::ST_AW: begin
				logic signed [34:0] w;
				w = 35'(sphd_pkg::K_TWO_THIRDS) - 35'(x2_q) + 35'(prod[62:31]);
				w_q <= w[34] ? 32'd0 : w[31:0];
			end
			sphd_pkg::ST_B6: w_q <= prod[61:30];
			sphd_pkg::ST_DHI: p_q <= prod;
			default: ;
		endcase
		if (state_q == sphd_pkg::ST_DOUT) begin
			logic [64:0] d;
			d = {prod[54:0], 10'd0} + 65'(p_q[63:22]);
			if (prod[63:38] != 26'd0 || d[64:48] != 17'd0) begin
				out_data.density <= sphd_pkg::DENS_MAX;
				out_data.saturated <= 1'b1;
			end else begin
				out_data.density <= d[47:0];
				out_data.saturated <= sat_q;
			end
		end
	end

	`SPH_ASSERT_NEXT(a_take_leaves_idle, clk, arst_n, take, state_q == sphd_pkg::ST_DX)
	`SPH_ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && out_stall, out_valid)
	`SPH_ASSERT_IMPL(a_no_take_busy, clk, arst_n, sqrt_busy |-> !take)
	`SPH_ASSERT_IMPL(a_out_only_last, clk, arst_n, out_valid |-> in_q.last)
endmodule
`default_nettype wire

// ===== tb/sph_density_summation_tb.sv =====
// testbench for the sph density summation block: directed and random pairs checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module sph_density_summation_tb;
	localparam int FRAC = sphd_pkg::COORD_FRAC_BITS_DEF;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sphd_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sphd_pkg::out_beat_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = sphd_pkg::REG_INV_H;
	logic [31:0] cfg_data = '0;

	int idle_cycles = 0;
	int send_idle_pct = 6;
	int recv_idle_pct = 69;
	bit hold_off = 1'b0;

	always #4 clk = ~clk;

	sph_density_summation dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// density predictor: own copy of registers and accumulator
	class density_board;
		logic [31:0] inv_h_r = sphd_pkg::INV_H_RESET;
		logic [31:0] kconst_r = sphd_pkg::KCONST_RESET;
		logic [63:0] sum = '0;
		bit sum_sat = 1'b0;
		int errors = 0;
		sphd_pkg::out_beat_t pending[$];

		task report(input string what, input logic [63:0] got, input logic [63:0] want);
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		function void write_reg(logic idx, logic [31:0] val);
			if (idx == sphd_pkg::REG_INV_H) inv_h_r = val;
			else kconst_r = val;
		endfunction

		function logic [65:0] root66(logic [65:0] v);
			logic [65:0] root, rem, trial;
			root = '0;
			rem = '0;
			for (int i = 32; i >= 0; i--) begin
				rem = (rem << 2) | ((v >> (2 * i)) & 66'd3);
				trial = (root << 2) | 66'd1;
				if (rem >= trial) begin
					rem = rem - trial;
					root = (root << 1) | 66'd1;
				end else begin
					root = root << 1;
				end
			end
			return root;
		endfunction

		function logic [63:0] kernel(sphd_pkg::in_beat_t b);
			logic signed [33:0] dx, dy, dz;
			logic [65:0] sq, r;
			logic [98:0] p;
			logic [63:0] q, q2, q3, u, u2, u3;
			logic signed [65:0] w;
			dx = 34'(b.target_x) - 34'(b.nb_x);
			dy = 34'(b.target_y) - 34'(b.nb_y);
			dz = 34'(b.target_z) - 34'(b.nb_z);
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			if (dz < 0) dz = -dz;
			sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
			r = root66(sq);
			p = 99'(r) * 99'(inv_h_r);
			if (p >= (99'd2 << (FRAC + 16))) return '0;
			q = 64'(p >> (FRAC + 16 - sphd_pkg::QF));
			if (q < (64'd1 << sphd_pkg::QF)) begin
				q2 = (q * q) >> sphd_pkg::QF;
				q3 = (q2 * q) >> sphd_pkg::QF;
				w = 66'(sphd_pkg::K_TWO_THIRDS) - 66'(q2) + 66'(q3 >> 1);
				return (w < 0) ? 64'd0 : 64'(w);
			end
			u = (64'd2 << sphd_pkg::QF) - q;
			u2 = (u * u) >> sphd_pkg::QF;
			u3 = (u2 * u) >> sphd_pkg::QF;
			return (u3 * 64'(sphd_pkg::K_ONE_SIXTH)) >> sphd_pkg::QF;
		endfunction

		function void note_pair(sphd_pkg::in_beat_t b);
			logic [95:0] term;
			logic [64:0] ns;
			logic [69:0] hi;
			logic [63:0] lo;
			logic [79:0] dens;
			sphd_pkg::out_beat_t o;
			if (b.first) begin
				sum = '0;
				sum_sat = 1'b0;
			end
			term = (96'(b.nb_weight) * 96'(kernel(b))) >> 24;
			ns = 65'(sum) + 65'(term[63:0]);
			if (ns[64]) begin
				sum = '1;
				sum_sat = 1'b1;
			end else begin
				sum = ns[63:0];
			end
			if (!b.last) return;
			hi = 70'(sum[63:32]) * 70'(kconst_r);
			lo = 64'(sum[31:0]) * 64'(kconst_r);
			o.saturated = sum_sat;
			if (hi >= (70'd1 << 38)) begin
				o.density = sphd_pkg::DENS_MAX;
				o.saturated = 1'b1;
			end else begin
				dens = (80'(hi) << 10) + 80'(lo >> 22);
				if (dens > 80'(sphd_pkg::DENS_MAX)) begin
					o.density = sphd_pkg::DENS_MAX;
					o.saturated = 1'b1;
				end else begin
					o.density = dens[47:0];
				end
			end
			pending.push_back(o);
		endfunction

		task check_result(sphd_pkg::out_beat_t got);
			sphd_pkg::out_beat_t want;
			if (pending.size() == 0) begin
				report("unexpected result beat", 64'(got), 64'd0);
				return;
			end
			want = pending.pop_front();
			if (got.density !== want.density) report("density", 64'(got.density), 64'(want.density));
			if (got.saturated !== want.saturated)
				report("saturated", 64'(got.saturated), 64'(want.saturated));
		endtask
	endclass

	density_board board = new();

	// result side: check every beat taken
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_result(out_data);
	end

	// receiver stall, random or held off for a long stretch
	always @(posedge clk) begin
		if (!arst_n) out_stall <= 1'b0;
		else if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog: cycles with no beat moved on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// valid stays up after a beat is taken until the next pair or an idle cycle
	task automatic send_pair(input sphd_pkg::in_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_pair(b);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		// a pair without last may still be in work
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		board.write_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($signed(32'($urandom_range(2 ** 21))) - (1 << 20));
			default: return 32'($signed(32'($urandom_range(2 ** 23))) - (1 << 22));
		endcase
	endfunction

	// a run: pairs around one target, first usually on the opening pair, last always on the closing one
	task automatic send_run(input int n);
		sphd_pkg::in_beat_t b;
		logic [31:0] tx, ty, tz;
		tx = rand_coord();
		ty = rand_coord();
		tz = rand_coord();
		for (int i = 0; i < n; i++) begin
			b.target_x = tx;
			b.target_y = ty;
			b.target_z = tz;
			b.nb_x = ($urandom_range(9) == 0) ? rand_coord() : tx + rand_coord() / 8;
			b.nb_y = ($urandom_range(9) == 0) ? rand_coord() : ty + rand_coord() / 8;
			b.nb_z = ($urandom_range(9) == 0) ? rand_coord() : tz + rand_coord() / 8;
			b.nb_weight = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(1 << 25);
			b.first = (i == 0) ? ($urandom_range(15) != 0) : ($urandom_range(30) == 0);
			b.last = (i == n - 1) ? 1'b1 : ($urandom_range(30) == 0);
			send_pair(b);
		end
	endtask

	task automatic directed();
		sphd_pkg::in_beat_t b;
		// coincident particles: q is zero, kernel at its peak
		b = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h0100_0000, 1'b1, 1'b1};
		send_pair(b);
		// q between 1 and 2 with inv_h of 20: distance 0.075
		b.nb_x = 32'sd1258291;
		send_pair(b);
		// q beyond 2: kernel zero
		b.nb_x = 32'sd16777216;
		send_pair(b);
		// coordinate extremes, farthest possible pair
		b = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1, 1'b1, 1'b1};
		send_pair(b);
		b = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, '1, 1'b1, 1'b0};
		send_pair(b);
		// run without first adds on, then a last pair, then another without first
		b.first = 1'b0;
		b.last = 1'b1;
		send_pair(b);
		send_pair(b);
		// long run of maximal weights
		b.first = 1'b1;
		b.last = 1'b0;
		send_pair(b);
		b.first = 1'b0;
		repeat (10) send_pair(b);
		b.last = 1'b1;
		send_pair(b);
		drain();
		// zero inv_h: every pair at q zero, and large constant for density clip
		write_reg(sphd_pkg::REG_INV_H, 32'd0);
		write_reg(sphd_pkg::REG_KCONST, 32'hffff_ffff);
		b = '{32'h1234_5678, 32'hedcb_a987, 32'h0, 32'h7fff_ffff, 32'h0, 32'h8000_0000,
			32'hffff_ffff, 1'b1, 1'b1};
		send_pair(b);
		b.nb_weight = 32'h0000_0001;
		send_pair(b);
		drain();
		write_reg(sphd_pkg::REG_INV_H, 32'hffff_ffff);
		write_reg(sphd_pkg::REG_KCONST, 32'd0);
		b = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'hffff_ffff, 1'b1, 1'b1};
		send_pair(b);
		b.nb_z = 32'h0;
		send_pair(b);
		drain();
	endtask

	initial begin
		int pairs;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		pairs = 0;
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 69;
				recv_idle_pct = 6;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// register settings for this phase
			case (ph)
				0: begin
					write_reg(sphd_pkg::REG_INV_H, sphd_pkg::INV_H_RESET);
					write_reg(sphd_pkg::REG_KCONST, sphd_pkg::KCONST_RESET);
				end
				1: begin
					write_reg(sphd_pkg::REG_INV_H, 32'd1 << 16);
					write_reg(sphd_pkg::REG_KCONST, $urandom());
				end
				default: begin
					write_reg(sphd_pkg::REG_INV_H, 32'd200 << 16);
					write_reg(sphd_pkg::REG_KCONST, 32'd1 << 16);
				end
			endcase
			if (ph == 2) begin
				// long receiver hold-off while pairs keep coming
				fork
					begin
						hold_off = 1'b1;
						repeat (600) @(posedge clk);
						hold_off = 1'b0;
					end
					repeat (6) send_run(1);
				join
			end
			while (pairs < (ph + 1) * 227) begin
				int n;
				n = $urandom_range(1, 8);
				send_run(n);
				pairs += n;
			end
			drain();
		end
		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire
